### hdl/gqm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gqm_pkg
// Shared types and codes for the greedy quad merge block.
// ----------------------------------------------------------------------------
package gqm_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] cell_value;
        logic [15:0] neighbor_value;
    } in_beat_t;

    typedef struct packed {
        logic        quad_found;
        logic [3:0]  quad_u;
        logic [3:0]  quad_v;
        logic [4:0]  quad_width;
        logic [4:0]  quad_height;
        logic [15:0] quad_block;
    } out_beat_t;

    // classified command from front to back
    typedef struct packed {
        logic        is_fetch;
        logic [15:0] value;
    } cmd_t;

endpackage
`default_nettype wire

### hdl/gqm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gqm_front
// Accept input beats, classify them and push them into a short command queue.
// ----------------------------------------------------------------------------
module gqm_front #(
    parameter int DEPTH = 4
) (
    input  wire               clk,
    input  wire               rst_n,
    input  gqm_pkg::in_beat_t in_beat,
    input  wire               push,
    output logic              full,
    output gqm_pkg::cmd_t     cmd,
    output logic              cmd_valid,
    input  wire               cmd_take
);
    import gqm_pkg::*;

    localparam int AW = $clog2(DEPTH);

    cmd_t           q_mem [DEPTH];
    logic [AW-1:0]  wr_reg, rd_reg;
    logic [AW:0]    cnt_reg;
    logic           do_push, do_pop;
    cmd_t           c_in;

    assign full      = (cnt_reg == (AW+1)'(DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;
    assign cmd       = q_mem[rd_reg];

    always_comb
    begin
        c_in.is_fetch = (in_beat.op == OP_FETCH);
        c_in.value    = (in_beat.cell_value != '0 && in_beat.neighbor_value == '0)
                        ? in_beat.cell_value : 16'd0;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_reg] <= c_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

endmodule
`default_nettype wire

### hdl/gqm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gqm_back
// Hold the slice mask and run loads and rectangle fetches.
// ----------------------------------------------------------------------------
module gqm_back #(
    parameter int GRID_SIDE = 16
) (
    input  wire                clk,
    input  wire                rst_n,
    input  gqm_pkg::cmd_t      cmd,
    input  wire                cmd_valid,
    output logic               cmd_take,
    output gqm_pkg::out_beat_t res,
    output logic               res_valid,
    input  wire                res_take
);
    import gqm_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int PW    = $clog2(CELLS);
    localparam int SW    = $clog2(GRID_SIDE);
    localparam int EW    = $clog2(GRID_SIDE + 1);
    localparam int CW    = SW + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_WIDE  = 6'b000100,
        S_ROW   = 6'b001000,
        S_CLEAR = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    logic [15:0]   mem [CELLS];
    logic [15:0]   rd_data;
    state_t        st_reg;
    logic          pend_reg;
    logic [PW-1:0] lpos_reg;
    logic [PW-1:0] cur_reg;
    logic [SW-1:0] cu_reg;
    logic [CW-1:0] cv_reg;
    logic [PW-1:0] base_reg;
    logic [PW-1:0] rowp_reg;
    logic [PW-1:0] ptr_reg;
    logic [SW-1:0] u_reg;
    logic [SW-1:0] v_reg;
    logic [EW-1:0] w_reg;
    logic [EW-1:0] h_reg;
    logic [EW-1:0] i_reg;
    logic [EW-1:0] j_reg;
    logic [15:0]   id_reg;
    logic          found_reg;
    out_beat_t     res_reg;
    logic          rv_reg;
    logic          load_en;
    logic          res_load;
    logic          at_end;
    logic [PW-1:0] rd_addr;
    logic [PW-1:0] cur_inc;
    logic [PW-1:0] row_next;
    logic [CW-1:0] u_span;
    logic [CW-1:0] v_span;

    assign res       = res_reg;
    assign res_valid = rv_reg;
    assign cmd_take  = (st_reg == S_IDLE) && cmd_valid;
    assign load_en   = cmd_take && !cmd.is_fetch;
    assign res_load  = (st_reg == S_EMIT) && (!rv_reg || res_take);
    assign at_end    = (cv_reg == CW'(GRID_SIDE));
    assign rd_addr   = (st_reg == S_SCAN) ? cur_reg : ptr_reg;
    assign cur_inc   = cur_reg + 1'b1;
    assign row_next  = rowp_reg + PW'(GRID_SIDE);
    assign u_span    = CW'(u_reg) + CW'(w_reg);
    assign v_span    = CW'(v_reg) + CW'(h_reg);

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            mem[lpos_reg] <= cmd.value;
        end
        else if (st_reg == S_CLEAR)
        begin
            mem[ptr_reg] <= 16'd0;
        end
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg  <= 1'b0;
            res_reg <= '0;
        end
        else if (res_load)
        begin
            rv_reg <= 1'b1;
            if (found_reg)
            begin
                res_reg.quad_found  <= 1'b1;
                res_reg.quad_u      <= 4'(u_reg);
                res_reg.quad_v      <= 4'(v_reg);
                res_reg.quad_width  <= 5'(w_reg);
                res_reg.quad_height <= 5'(h_reg);
                res_reg.quad_block  <= id_reg;
            end
            else
            begin
                res_reg <= '0;
            end
        end
        else if (res_take)
        begin
            rv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            pend_reg  <= 1'b0;
            lpos_reg  <= '0;
            cur_reg   <= '0;
            cu_reg    <= '0;
            cv_reg    <= '0;
            base_reg  <= '0;
            rowp_reg  <= '0;
            ptr_reg   <= '0;
            u_reg     <= '0;
            v_reg     <= '0;
            w_reg     <= '0;
            h_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            id_reg    <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    if (load_en)
                    begin
                        lpos_reg <= (lpos_reg == PW'(CELLS - 1)) ? '0 : lpos_reg + 1'b1;
                        cur_reg  <= '0;
                        cu_reg   <= '0;
                        cv_reg   <= '0;
                    end
                    else if (cmd_take)
                    begin
                        pend_reg <= 1'b0;
                        st_reg   <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (!pend_reg)
                    begin
                        if (at_end)
                        begin
                            found_reg <= 1'b0;
                            st_reg    <= S_EMIT;
                        end
                        else
                        begin
                            pend_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        cur_reg  <= cur_inc;
                        cu_reg   <= (cu_reg == SW'(GRID_SIDE - 1)) ? '0 : cu_reg + 1'b1;
                        cv_reg   <= (cu_reg == SW'(GRID_SIDE - 1)) ? cv_reg + 1'b1 : cv_reg;
                        if (rd_data != 16'd0)
                        begin
                            id_reg    <= rd_data;
                            found_reg <= 1'b1;
                            u_reg     <= cu_reg;
                            v_reg     <= cv_reg[SW-1:0];
                            base_reg  <= cur_reg;
                            rowp_reg  <= cur_reg;
                            ptr_reg   <= cur_inc;
                            w_reg     <= EW'(1);
                            h_reg     <= EW'(1);
                            st_reg    <= S_WIDE;
                        end
                    end
                end
                S_WIDE:
                begin
                    if (!pend_reg)
                    begin
                        if (u_span >= CW'(GRID_SIDE))
                        begin
                            rowp_reg <= row_next;
                            ptr_reg  <= row_next;
                            i_reg    <= '0;
                            st_reg   <= S_ROW;
                        end
                        else
                        begin
                            pend_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (rd_data == id_reg)
                        begin
                            w_reg   <= w_reg + 1'b1;
                            ptr_reg <= ptr_reg + 1'b1;
                        end
                        else
                        begin
                            rowp_reg <= row_next;
                            ptr_reg  <= row_next;
                            i_reg    <= '0;
                            st_reg   <= S_ROW;
                        end
                    end
                end
                S_ROW:
                begin
                    if (!pend_reg)
                    begin
                        if (v_span >= CW'(GRID_SIDE))
                        begin
                            ptr_reg  <= base_reg;
                            rowp_reg <= base_reg;
                            i_reg    <= '0;
                            j_reg    <= '0;
                            st_reg   <= S_CLEAR;
                        end
                        else if (i_reg == w_reg)
                        begin
                            h_reg    <= h_reg + 1'b1;
                            i_reg    <= '0;
                            rowp_reg <= row_next;
                            ptr_reg  <= row_next;
                        end
                        else
                        begin
                            pend_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (rd_data == id_reg)
                        begin
                            i_reg   <= i_reg + 1'b1;
                            ptr_reg <= ptr_reg + 1'b1;
                        end
                        else
                        begin
                            ptr_reg  <= base_reg;
                            rowp_reg <= base_reg;
                            i_reg    <= '0;
                            j_reg    <= '0;
                            st_reg   <= S_CLEAR;
                        end
                    end
                end
                S_CLEAR:
                begin
                    if (i_reg + 1'b1 == w_reg)
                    begin
                        i_reg <= '0;
                        if (j_reg + 1'b1 == h_reg)
                        begin
                            st_reg <= S_EMIT;
                        end
                        else
                        begin
                            j_reg    <= j_reg + 1'b1;
                            rowp_reg <= row_next;
                            ptr_reg  <= row_next;
                        end
                    end
                    else
                    begin
                        i_reg   <= i_reg + 1'b1;
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                S_EMIT:
                begin
                    if (res_load)
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### hdl/greedy_quad_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_quad_merge
// Greedy rectangle merge over one square slice mask.
// ----------------------------------------------------------------------------
// Load: queued at its push edge, written to the mask once the back end is idle;
// one per cycle while the queue has room and the back end stays idle.
// Fetch: queued, then scans from the cursor, compares while widening and growing,
// checks edges and full rows, clears cells, registers result; single mask read port.
// Reset clears positions, queue and result; the mask is undefined until loaded.
module greedy_quad_merge #(
    parameter int GRID_SIDE = 16
) (
    input  wire                clk,
    input  wire                rst_n,
    input  gqm_pkg::in_beat_t  in_beat,
    input  wire                push,
    output logic               full,
    output gqm_pkg::out_beat_t out_beat,
    output logic               empty,
    input  wire                pop
);
    import gqm_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_take, res_valid;

    gqm_front #(.DEPTH(4)) u_front (
        .clk(clk), .rst_n(rst_n), .in_beat(in_beat), .push(push), .full(full),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
    );

    gqm_back #(.GRID_SIDE(GRID_SIDE)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid),
        .cmd_take(cmd_take), .res(out_beat), .res_valid(res_valid),
        .res_take(pop)
    );

    assign empty = !res_valid;

endmodule
`default_nettype wire
